// ===== rtl/ctdb_pkg.sv =====
// Shared types, constants and helper functions for the clock/date converter.
`default_nettype none
package ctdb_pkg;

	localparam int unsigned EPOCH_YEAR = 1980;

	localparam logic [1:0] REQ_TICKS = 2'd0;
	localparam logic [1:0] REQ_BCD   = 2'd1;
	localparam logic [1:0] REQ_SET   = 2'd2;

	localparam logic [21:0] TICKS_PER_HOUR = 22'd65520;
	localparam logic [21:0] TICKS_PER_MIN  = 22'd1092;
	localparam logic [21:0] TICKS_PER_SEC  = 22'd18;
	localparam logic [21:0] TICK_DIV       = 22'd182;
	localparam logic [21:0] TICK_MAX       = 22'h1FFFFF;

	typedef enum logic [4:0] {
		S_IDLE,
		S_HR,
		S_MIN,
		S_SECL,
		S_SEC,
		S_MOD,
		S_HUNL,
		S_HUN,
		S_R1A,
		S_R1B,
		S_TH,
		S_TM,
		S_TS,
		S_YEAR,
		S_MON,
		S_DAY,
		S_FIN
	} state_t;

	typedef struct packed {
		logic [21:0] diff;
		logic        ge;
		logic        eq;
	} alu_res_t;

	// first day offset of month index k (0 = January, 12 = whole year)
	function automatic logic [8:0] month_start(input logic lp, input logic [3:0] k);
		logic [8:0] base;
		case (k)
			4'd0:    base = 9'd0;
			4'd1:    base = 9'd31;
			4'd2:    base = 9'd59;
			4'd3:    base = 9'd90;
			4'd4:    base = 9'd120;
			4'd5:    base = 9'd151;
			4'd6:    base = 9'd181;
			4'd7:    base = 9'd212;
			4'd8:    base = 9'd243;
			4'd9:    base = 9'd273;
			4'd10:   base = 9'd304;
			4'd11:   base = 9'd334;
			default: base = 9'd365;
		endcase
		if (lp && k >= 4'd2)
			base = base + 9'd1;
		return base;
	endfunction

	function automatic logic [7:0] bcd2bin(input logic [7:0] b);
		return 8'(b[7:4] * 8'd10) + 8'(b[3:0]);
	endfunction

	function automatic logic [6:0] sat99(input logic [7:0] v);
		return (v > 8'd99) ? 7'd99 : v[6:0];
	endfunction

	// valid for v < 100
	function automatic logic [7:0] bin2bcd(input logic [6:0] v);
		logic [14:0] p;
		logic [3:0]  t;
		logic [6:0]  o;
		p = 15'(v) * 15'd205;
		t = p[14:11];
		o = v - 7'(t * 7'd10);
		return {t, o[3:0]};
	endfunction

endpackage
`default_nettype wire

// ===== rtl/ctdb_alu.sv =====
// Shared subtract/compare unit used by every conversion loop.
`default_nettype none
module ctdb_alu
	import ctdb_pkg::*;
(
	input  logic [21:0] a,
	input  logic [21:0] b,
	output alu_res_t    res
);

	logic [22:0] d;

	assign d        = {1'b0, a} - {1'b0, b};
	assign res.diff = d[21:0];
	assign res.ge   = ~d[22];
	assign res.eq   = (d[21:0] == 22'd0);

endmodule
`default_nettype wire

// ===== rtl/clock_tick_date_bcd_converter_unit.sv =====
// Top level: clock tick / BCD date converter with kept day counter.
//
// Channel  Handshake            Payload
// in       in_valid/in_ready    req_type rollover tick_count bcd_date bcd_time
//                               day_count hours_in minutes_in seconds_in
// out      out_valid/out_ready  days_out hours_out minutes_out seconds_out
//                               hundredths_out date_valid ticks_out
//                               bcd_date_out bcd_time_out
//
// One request at a time; every subtraction loop goes through one subtract/compare unit.
// req 0: hours, minutes, seconds and hundredths by repeated subtraction.
// req 1: direct BCD decode. req 2: years past epoch, then month, by subtraction.
// req 3 is taken and dropped. Reset clears the day counter to 1.
// The result register lets the next request start while out is stalled.
`default_nettype none
module clock_tick_date_bcd_converter_unit
	import ctdb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic        rollover,
	input  logic [20:0] tick_count,
	input  logic [31:0] bcd_date,
	input  logic [23:0] bcd_time,
	input  logic [15:0] day_count,
	input  logic [4:0]  hours_in,
	input  logic [5:0]  minutes_in,
	input  logic [5:0]  seconds_in,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] days_out,
	output logic [6:0]  hours_out,
	output logic [6:0]  minutes_out,
	output logic [6:0]  seconds_out,
	output logic [6:0]  hundredths_out,
	output logic        date_valid,
	output logic [20:0] ticks_out,
	output logic [31:0] bcd_date_out,
	output logic [23:0] bcd_time_out
);

	state_t      state_q, state_d;
	logic        out_valid_q;
	logic [15:0] day_ctr_q;

	logic [1:0]  rtype_q;
	logic [31:0] date_q;
	logic [23:0] time_q;
	logic [4:0]  h_q;
	logic [5:0]  m_q;
	logic [5:0]  s_q;

	logic [21:0] rem_q;
	logic [21:0] wrk_q;
	logic [6:0]  cnt_q;
	logic [14:0] year_q;
	logic [3:0]  k_q;
	logic [7:0]  day_q;
	logic [3:0]  mon_q;
	logic [6:0]  hrs_q, min_q, sec_q, hun_q;
	logic [15:0] rdays_q;
	logic        rvalid_q;

	logic [15:0] days_q;
	logic [6:0]  hours_q, minutes_q, seconds_q, hund_q;
	logic        dvalid_q;
	logic [20:0] ticks_q;
	logic [31:0] bdate_q;
	logic [23:0] btime_q;

	logic [21:0] alu_a, alu_b;
	alu_res_t    alu;
	logic        accept, fin_load, lp;
	logic [8:0]  year_len;

	// request 1 helpers
	logic [7:0]  r1_mon;
	logic [3:0]  r1_idx;
	logic [14:0] span;
	logic [24:0] r1_sum;

	// request 2 result helpers
	logic [6:0]  cent, yy;

	ctdb_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.res (alu)
	);

	assign lp       = (year_q[1:0] == 2'd0);
	assign year_len = lp ? 9'd366 : 9'd365;
	assign accept   = in_valid & in_ready;
	assign fin_load = (state_q == S_FIN) && (!out_valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (req_type)
						REQ_TICKS: state_d = S_HR;
						REQ_BCD:   state_d = S_R1A;
						REQ_SET:   state_d = S_TH;
						default:   state_d = S_IDLE;
					endcase
				end
			end
			S_HR:   if (!alu.ge) state_d = S_MIN;
			S_MIN:  if (!alu.ge) state_d = S_SECL;
			S_SECL: state_d = S_SEC;
			S_SEC:  if (!alu.ge) state_d = S_MOD;
			S_MOD:  if (!alu.ge) state_d = S_HUNL;
			S_HUNL: state_d = S_HUN;
			S_HUN:  if (!alu.ge) state_d = S_FIN;
			S_R1A:  state_d = S_R1B;
			S_R1B:  state_d = S_FIN;
			S_TH:   state_d = S_TM;
			S_TM:   state_d = S_TS;
			S_TS:   state_d = S_YEAR;
			S_YEAR: if (!(alu.ge && !alu.eq)) state_d = S_MON;
			S_MON:  if (alu.ge) state_d = S_DAY;
			S_DAY:  state_d = S_FIN;
			S_FIN:  if (!out_valid_q || out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		alu_a    = 22'd0;
		alu_b    = 22'd0;
		unique case (state_q)
			S_IDLE: in_ready = 1'b1;
			S_HR: begin
				alu_a = rem_q;
				alu_b = TICKS_PER_HOUR;
			end
			S_MIN: begin
				alu_a = rem_q;
				alu_b = TICKS_PER_MIN;
			end
			S_SEC, S_HUN: begin
				alu_a = wrk_q;
				alu_b = TICK_DIV;
			end
			S_MOD: begin
				alu_a = rem_q;
				alu_b = TICK_DIV;
			end
			S_YEAR: begin
				alu_a = rem_q;
				alu_b = 22'(year_len);
			end
			S_MON: begin
				alu_a = 22'(month_start(lp, k_q));
				alu_b = rem_q;
			end
			S_DAY: begin
				alu_a = rem_q;
				alu_b = 22'(month_start(lp, k_q - 4'd1));
			end
			default: ;
		endcase
	end

	always_comb begin
		r1_mon = bcd2bin(date_q[15:8]);
		if (r1_mon == 8'd0)
			r1_idx = 4'd0;
		else if (r1_mon > 8'd13)
			r1_idx = 4'd12;
		else
			r1_idx = 4'(r1_mon - 8'd1);
		span   = year_q - 15'(EPOCH_YEAR);
		r1_sum = 25'(day_q) + 25'(month_start(lp, k_q)) + 25'(span) * 25'd365
			+ 25'((span + 15'd3) >> 2);
		if (year_q >= 15'd2100) begin
			cent = 7'd21;
			yy   = 7'(year_q - 15'd2100);
		end else if (year_q >= 15'd2000) begin
			cent = 7'd20;
			yy   = 7'(year_q - 15'd2000);
		end else begin
			cent = 7'd19;
			yy   = 7'(year_q - 15'd1900);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			day_ctr_q   <= 16'd1;
		end else begin
			state_q <= state_d;
			if (fin_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (accept && req_type == REQ_TICKS && rollover)
				day_ctr_q <= day_ctr_q + 16'd1;
			else if (accept && req_type == REQ_SET)
				day_ctr_q <= day_count;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				rtype_q <= req_type;
				date_q  <= bcd_date;
				time_q  <= bcd_time;
				h_q     <= hours_in;
				m_q     <= minutes_in;
				s_q     <= seconds_in;
				cnt_q   <= 7'd0;
				year_q  <= 15'(EPOCH_YEAR);
				k_q     <= 4'd1;
				if (req_type == REQ_SET)
					rem_q <= {6'd0, day_count};
				else
					rem_q <= {1'b0, tick_count};
			end
			S_HR, S_MIN, S_MOD: begin
				if (alu.ge) begin
					rem_q <= alu.diff;
					if (state_q != S_MOD)
						cnt_q <= cnt_q + 7'd1;
				end else begin
					cnt_q <= 7'd0;
					if (state_q == S_HR)
						hrs_q <= cnt_q;
					else if (state_q == S_MIN)
						min_q <= cnt_q;
				end
			end
			S_SECL: wrk_q <= {8'd0, 14'(rem_q[10:0] * 14'd10)};
			S_HUNL: wrk_q <= {7'd0, 15'(rem_q[7:0] * 15'd100)};
			S_SEC, S_HUN: begin
				if (alu.ge) begin
					wrk_q <= alu.diff;
					cnt_q <= cnt_q + 7'd1;
				end else begin
					cnt_q <= 7'd0;
					if (state_q == S_SEC)
						sec_q <= cnt_q;
					else
						hun_q <= cnt_q;
				end
			end
			S_R1A: begin
				year_q <= 15'(bcd2bin(date_q[31:24])) * 15'd100
					+ 15'(bcd2bin(date_q[23:16]));
				k_q    <= r1_idx;
				day_q  <= bcd2bin(date_q[7:0]);
				hrs_q  <= sat99(bcd2bin(time_q[23:16]));
				min_q  <= sat99(bcd2bin(time_q[15:8]));
				sec_q  <= sat99(bcd2bin(time_q[7:0]));
			end
			S_R1B: begin
				if (year_q >= 15'(EPOCH_YEAR)) begin
					rdays_q  <= r1_sum[15:0];
					rvalid_q <= 1'b1;
				end else begin
					rdays_q  <= 16'd0;
					rvalid_q <= 1'b0;
				end
			end
			S_TH: wrk_q <= 22'(h_q) * TICKS_PER_HOUR;
			S_TM: wrk_q <= wrk_q + 22'(m_q) * TICKS_PER_MIN;
			S_TS: wrk_q <= wrk_q + 22'(s_q) * TICKS_PER_SEC;
			S_YEAR: begin
				if (alu.ge && !alu.eq) begin
					rem_q  <= alu.diff;
					year_q <= year_q + 15'd1;
				end
			end
			S_MON: begin
				if (alu.ge)
					mon_q <= k_q;
				else
					k_q <= k_q + 4'd1;
			end
			S_DAY: day_q <= alu.diff[7:0];
			S_FIN: begin
				if (fin_load) begin
					days_q    <= 16'd0;
					hours_q   <= 7'd0;
					minutes_q <= 7'd0;
					seconds_q <= 7'd0;
					hund_q    <= 7'd0;
					dvalid_q  <= 1'b0;
					ticks_q   <= 21'd0;
					bdate_q   <= 32'd0;
					btime_q   <= 24'd0;
					case (rtype_q)
						REQ_TICKS: begin
							days_q    <= day_ctr_q;
							hours_q   <= hrs_q;
							minutes_q <= min_q;
							seconds_q <= sec_q;
							hund_q    <= hun_q;
						end
						REQ_BCD: begin
							days_q    <= rdays_q;
							hours_q   <= hrs_q;
							minutes_q <= min_q;
							seconds_q <= sec_q;
							dvalid_q  <= rvalid_q;
						end
						default: begin
							ticks_q <= (wrk_q > TICK_MAX) ? TICK_MAX[20:0] : wrk_q[20:0];
							bdate_q <= {bin2bcd(cent), bin2bcd(yy),
								bin2bcd({3'd0, mon_q}), bin2bcd(day_q[6:0])};
							btime_q <= {bin2bcd({2'd0, h_q}), bin2bcd({1'b0, m_q}),
								bin2bcd({1'b0, s_q})};
						end
					endcase
				end
			end
			default: ;
		endcase
	end

	assign out_valid      = out_valid_q;
	assign days_out       = days_q;
	assign hours_out      = hours_q;
	assign minutes_out    = minutes_q;
	assign seconds_out    = seconds_q;
	assign hundredths_out = hund_q;
	assign date_valid     = dvalid_q;
	assign ticks_out      = ticks_q;
	assign bcd_date_out   = bdate_q;
	assign bcd_time_out   = btime_q;

endmodule
`default_nettype wire

// ===== tb/clock_tick_date_bcd_converter_unit_test.sv =====
// Self-checking testbench for the clock tick / BCD date converter unit.
module clock_tick_date_bcd_converter_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import ctdb_pkg::*;

	localparam logic [1:0] REQ_NONE = 2'd3;
	localparam int ITEMS = 1100;
	localparam int CALM_TAIL = 100;
	localparam int TAIL_CYCLES = 300;
	localparam int MAX_PRINTS = 40;

	typedef struct packed {
		logic [1:0]  req_type;
		logic        rollover;
		logic [20:0] tick_count;
		logic [31:0] bcd_date;
		logic [23:0] bcd_time;
		logic [15:0] day_count;
		logic [4:0]  hours_in;
		logic [5:0]  minutes_in;
		logic [5:0]  seconds_in;
	} request_t;

	typedef struct packed {
		logic [15:0] days;
		logic [6:0]  hours;
		logic [6:0]  minutes;
		logic [6:0]  seconds;
		logic [6:0]  hundredths;
		logic        date_ok;
		logic [20:0] ticks;
		logic [31:0] date_bcd;
		logic [23:0] time_bcd;
	} result_t;

	typedef struct {
		request_t req;
		bit       typed;
		result_t  want;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  req_type = REQ_TICKS;
	logic        rollover = 1'b0;
	logic [20:0] tick_count = '0;
	logic [31:0] bcd_date = '0;
	logic [23:0] bcd_time = '0;
	logic [15:0] day_count = '0;
	logic [4:0]  hours_in = '0;
	logic [5:0]  minutes_in = '0;
	logic [5:0]  seconds_in = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] days_out;
	logic [6:0]  hours_out;
	logic [6:0]  minutes_out;
	logic [6:0]  seconds_out;
	logic [6:0]  hundredths_out;
	logic        date_valid;
	logic [20:0] ticks_out;
	logic [31:0] bcd_date_out;
	logic [23:0] bcd_time_out;

	logic [15:0]  kept_days = 16'd1;
	result_t      pending_results[$];
	row_t         directed[$];
	int           mismatch_count = 0;
	int           stall_left = 0;
	bit           calm = 1'b0;

	int unsigned days_before_month[2][13] = '{
		'{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365},
		'{0, 31, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335, 366}
	};

	clock_tick_date_bcd_converter_unit u_top (.*);

	always #1 clk = ~clk;

	function automatic int unsigned bcd_to_bin(input logic [7:0] b);
		return b[7:4] * 10 + b[3:0];
	endfunction

	function automatic logic [7:0] to_bcd(input int unsigned v);
		return 8'(((v / 10) << 4) | (v % 10));
	endfunction

	function automatic bit leap_year(input int unsigned y);
		return (y & 3) == 0;
	endfunction

	function automatic int unsigned cap99(input int unsigned v);
		return (v > 99) ? 99 : v;
	endfunction

	// updates kept_days; returns 0 when the request yields no result
	function automatic bit convert_request(input request_t r, output result_t res);
		int unsigned t, rem, yr, idx, span, year, c, len, mon, day, k;
		bit lp;
		res = '0;
		case (r.req_type)
			REQ_TICKS: begin
				if (r.rollover)
					kept_days = kept_days + 16'd1;
				res.days = kept_days;
				t = r.tick_count;
				res.hours = 7'(t / TICKS_PER_HOUR);
				rem = t % TICKS_PER_HOUR;
				res.minutes = 7'(rem / TICKS_PER_MIN);
				rem = rem % TICKS_PER_MIN;
				res.seconds = 7'(rem * 10 / TICK_DIV);
				rem = rem % TICK_DIV;
				res.hundredths = 7'(rem * 100 / TICK_DIV);
			end
			REQ_BCD: begin
				day = bcd_to_bin(r.bcd_date[7:0]);
				mon = bcd_to_bin(r.bcd_date[15:8]);
				yr = bcd_to_bin(r.bcd_date[31:24]) * 100 + bcd_to_bin(r.bcd_date[23:16]);
				res.hours = 7'(cap99(bcd_to_bin(r.bcd_time[23:16])));
				res.minutes = 7'(cap99(bcd_to_bin(r.bcd_time[15:8])));
				res.seconds = 7'(cap99(bcd_to_bin(r.bcd_time[7:0])));
				if (yr >= EPOCH_YEAR) begin
					idx = (mon == 0) ? 0 : mon - 1;
					if (idx > 12)
						idx = 12;
					span = yr - EPOCH_YEAR;
					res.days = 16'(day + days_before_month[leap_year(yr)][idx]
						+ span * 365 + (span + 3) / 4);
					res.date_ok = 1'b1;
				end
			end
			REQ_SET: begin
				kept_days = r.day_count;
				t = r.hours_in * TICKS_PER_HOUR + r.minutes_in * TICKS_PER_MIN
					+ r.seconds_in * TICKS_PER_SEC;
				res.ticks = (t > TICK_MAX) ? 21'(TICK_MAX) : 21'(t);
				year = EPOCH_YEAR;
				c = r.day_count;
				len = leap_year(year) ? 366 : 365;
				while (c > len) begin
					c = c - len;
					year++;
					len = leap_year(year) ? 366 : 365;
				end
				lp = (len == 366);
				mon = 1;
				day = c;
				for (k = 1; k < 13; k++) begin
					if (days_before_month[lp][k] >= c) begin
						mon = k;
						day = c - days_before_month[lp][k - 1];
						break;
					end
				end
				res.date_bcd = {to_bcd(year / 100), to_bcd(year % 100), to_bcd(mon),
					to_bcd(day)};
				res.time_bcd = {to_bcd(r.hours_in), to_bcd(r.minutes_in),
					to_bcd(r.seconds_in)};
			end
			default: return 1'b0;
		endcase
		return 1'b1;
	endfunction

	function automatic request_t mk_req(input logic [1:0] rt, input logic ro,
			input logic [20:0] tk, input logic [31:0] dt, input logic [23:0] tm,
			input logic [15:0] dc, input logic [4:0] h, input logic [5:0] m,
			input logic [5:0] s);
		return '{rt, ro, tk, dt, tm, dc, h, m, s};
	endfunction

	function automatic result_t mk_res(input logic [15:0] d, input logic [6:0] h,
			input logic [6:0] m, input logic [6:0] s, input logic [6:0] hd,
			input logic ok, input logic [20:0] tk, input logic [31:0] dt,
			input logic [23:0] tm);
		return '{d, h, m, s, hd, ok, tk, dt, tm};
	endfunction

	task automatic add_row(input request_t r, input bit typed, input result_t w);
		row_t row;
		row.req = r;
		row.typed = typed;
		row.want = w;
		directed.push_back(row);
	endtask

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTS)
			$display("%0t ns mismatch: %s", $time, msg);
	endtask

	task automatic compare_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
	endtask

	task automatic check_result();
		result_t want;
		if (pending_results.size() == 0) begin
			report_mismatch("result transfer with no request pending");
			return;
		end
		want = pending_results.pop_front();
		compare_field("days_out", days_out, want.days);
		compare_field("hours_out", hours_out, want.hours);
		compare_field("minutes_out", minutes_out, want.minutes);
		compare_field("seconds_out", seconds_out, want.seconds);
		compare_field("hundredths_out", hundredths_out, want.hundredths);
		compare_field("date_valid", date_valid, want.date_ok);
		compare_field("ticks_out", ticks_out, want.ticks);
		compare_field("bcd_date_out", bcd_date_out, want.date_bcd);
		compare_field("bcd_time_out", bcd_time_out, want.time_bcd);
	endtask

	task automatic send_request(input request_t r, input bit typed, input result_t w);
		result_t want;
		int gap;
		gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= r.req_type;
		rollover <= r.rollover;
		tick_count <= r.tick_count;
		bcd_date <= r.bcd_date;
		bcd_time <= r.bcd_time;
		day_count <= r.day_count;
		hours_in <= r.hours_in;
		minutes_in <= r.minutes_in;
		seconds_in <= r.seconds_in;
		do @(posedge clk); while (!in_ready);
		if (convert_request(r, want)) begin
			if (typed)
				want = w;
			pending_results.push_back(want);
		end
	endtask

	// result side: check every transfer, stall in random bursts
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			check_result();
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 13);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	initial begin
		#3_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		request_t r;
		int sent;
		int pick;
		int unsigned yr;
		bit drained;

		add_row(mk_req(REQ_TICKS, 0, 0, 0, 0, 0, 0, 0, 0), 1,
			mk_res(1, 0, 0, 0, 0, 0, 0, 0, 0));
		add_row(mk_req(REQ_TICKS, 1, 21'h1FFFFF, 0, 0, 0, 0, 0, 0), 1,
			mk_res(2, 32, 0, 28, 80, 0, 0, 0, 0));
		add_row(mk_req(REQ_TICKS, 0, 1572479, 32'hFFFFFFFF, 24'hFFFFFF, 16'hFFFF, 31, 63, 63),
			0, '0);
		add_row(mk_req(REQ_BCD, 0, 0, 32'h19800101, 0, 0, 0, 0, 0), 1,
			mk_res(1, 0, 0, 0, 0, 1, 0, 0, 0));
		add_row(mk_req(REQ_BCD, 0, 0, 32'h19791231, 24'h235959, 0, 0, 0, 0), 1,
			mk_res(0, 23, 59, 59, 0, 0, 0, 0, 0));
		add_row(mk_req(REQ_BCD, 1, 21'h1FFFFF, 32'hFFFFFFFF, 24'hFFFFFF, 16'hFFFF, 31, 63, 63),
			0, '0);
		add_row(mk_req(REQ_BCD, 0, 0, 32'h19850015, 24'h120000, 0, 0, 0, 0), 0, '0);
		add_row(mk_req(REQ_BCD, 0, 0, 32'h19851301, 0, 0, 0, 0, 0), 0, '0);
		add_row(mk_req(REQ_BCD, 0, 0, 32'h20249907, 24'h995999, 0, 0, 0, 0), 0, '0);
		add_row(mk_req(REQ_BCD, 0, 0, 32'h1A9F0A0B, 24'h9AF05C, 0, 0, 0, 0), 0, '0);
		add_row(mk_req(REQ_BCD, 0, 0, 32'h21991231, 24'h000001, 0, 0, 0, 0), 0, '0);
		add_row(mk_req(REQ_SET, 0, 0, 0, 0, 0, 0, 0, 0), 1,
			mk_res(0, 0, 0, 0, 0, 0, 0, 32'h19800100, 0));
		add_row(mk_req(REQ_TICKS, 0, 0, 0, 0, 0, 0, 0, 0), 1,
			mk_res(0, 0, 0, 0, 0, 0, 0, 0, 0));
		add_row(mk_req(REQ_SET, 0, 0, 0, 0, 1, 23, 59, 59), 1,
			mk_res(0, 0, 0, 0, 0, 0, 1572450, 32'h19800101, 24'h235959));
		add_row(mk_req(REQ_SET, 0, 0, 0, 0, 366, 0, 0, 0), 1,
			mk_res(0, 0, 0, 0, 0, 0, 0, 32'h19801231, 0));
		add_row(mk_req(REQ_SET, 0, 0, 0, 0, 367, 0, 0, 0), 1,
			mk_res(0, 0, 0, 0, 0, 0, 0, 32'h19810101, 0));
		add_row(mk_req(REQ_SET, 0, 0, 0, 0, 60, 0, 0, 0), 1,
			mk_res(0, 0, 0, 0, 0, 0, 0, 32'h19800229, 0));
		add_row(mk_req(REQ_SET, 0, 0, 0, 0, 31, 0, 0, 0), 1,
			mk_res(0, 0, 0, 0, 0, 0, 0, 32'h19800131, 0));
		add_row(mk_req(REQ_SET, 1, 21'h1FFFFF, 32'hFFFFFFFF, 24'hFFFFFF, 16'hFFFF, 31, 63, 63),
			0, '0);
		add_row(mk_req(REQ_TICKS, 1, 0, 0, 0, 0, 0, 0, 0), 1,
			mk_res(0, 0, 0, 0, 0, 0, 0, 0, 0));
		add_row(mk_req(REQ_NONE, 1, 21'h1FFFFF, 32'hFFFFFFFF, 24'hFFFFFF, 16'h1234, 31, 63, 63),
			0, '0);
		add_row(mk_req(REQ_TICKS, 0, 65519, 0, 0, 0, 0, 0, 0), 0, '0);
		add_row(mk_req(REQ_SET, 0, 0, 0, 0, 1096, 12, 34, 56), 0, '0);
		add_row(mk_req(REQ_TICKS, 1, 1092, 0, 0, 0, 0, 0, 0), 0, '0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		kept_days = 16'd1;
		@(posedge clk);

		foreach (directed[i])
			send_request(directed[i].req, directed[i].typed, directed[i].want);

		sent = 0;
		drained = 1'b0;
		while (sent < ITEMS) begin
			calm = (sent >= ITEMS - CALM_TAIL) || ((sent / 50) % 6 == 5);
			if (!drained && sent >= ITEMS / 2) begin
				drained = 1'b1;
				in_valid <= 1'b0;
				@(posedge clk);
				while (pending_results.size() != 0)
					@(posedge clk);
			end
			r.rollover = $urandom_range(0, 3) == 0;
			r.tick_count = 21'($urandom);
			r.bcd_date = $urandom;
			r.bcd_time = 24'($urandom);
			r.day_count = 16'($urandom);
			r.hours_in = 5'($urandom);
			r.minutes_in = 6'($urandom);
			r.seconds_in = 6'($urandom);
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				r.req_type = REQ_NONE;
			end else if (pick < 36) begin
				r.req_type = REQ_TICKS;
				if ($urandom_range(0, 4) != 0)
					r.tick_count = 21'($urandom_range(0, 1572479));
			end else if (pick < 68) begin
				r.req_type = REQ_BCD;
				if ($urandom_range(0, 6) != 0) begin
					yr = $urandom_range(1975, 2110);
					r.bcd_date = {to_bcd(yr / 100), to_bcd(yr % 100),
						to_bcd($urandom_range(1, 12)), to_bcd($urandom_range(1, 31))};
					r.bcd_time = {to_bcd($urandom_range(0, 23)), to_bcd($urandom_range(0, 59)),
						to_bcd($urandom_range(0, 59))};
				end
			end else begin
				r.req_type = REQ_SET;
				pick = $urandom_range(0, 9);
				if (pick < 6)
					r.day_count = 16'($urandom_range(0, 15000));
				else if (pick == 9)
					r.day_count = 16'($urandom_range(65000, 65535));
				if ($urandom_range(0, 6) != 0) begin
					r.hours_in = 5'($urandom_range(0, 23));
					r.minutes_in = 6'($urandom_range(0, 59));
					r.seconds_in = 6'($urandom_range(0, 59));
				end
			end
			send_request(r, 1'b0, '0);
			if (r.req_type != REQ_NONE)
				sent++;
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/ctdb_pkg.sv
rtl/ctdb_alu.sv
rtl/clock_tick_date_bcd_converter_unit.sv
tb/clock_tick_date_bcd_converter_unit_test.sv
